// ----- rtl/core/contiguous_fit_allocator_assert.svh -----
// Assertion macros shared by the allocator RTL.
// Included by modules that carry concurrent checks.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_ASSERT_SVH
// Implication check under reset.
`define CFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication check under reset.
`define CFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/core/cfa_pkg.sv -----
// Package for the contiguous fit allocator: codes and types.
// No dependencies.
package cfa_pkg;
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StNoOwner = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;
  localparam logic [1:0] PolFirst  = 2'd0;
  localparam logic [1:0] PolBest   = 2'd1;
  localparam logic [1:0] PolWorst  = 2'd2;
  localparam logic       ReqAlloc  = 1'b0;
  localparam logic       ReqFree   = 1'b1;
  localparam int unsigned AddrW = 20;
  localparam int unsigned LenW  = 21;
  localparam int unsigned OwnW  = 16;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  len;
    logic             free;
    logic [OwnW-1:0]  owner;
  } seg_t;

  typedef struct packed {
    logic             req_type;
    logic [OwnW-1:0]  owner_id;
    logic [LenW-1:0]  request_size;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] address;
    logic [LenW-1:0]  total_free;
    logic [LenW-1:0]  largest_free;
    logic [LenW-1:0]  external_frag;
  } rsp_t;
endpackage

// ----- rtl/core/cfa_if.sv -----
// Valid/ready channel interface carrying one word of type T.
// No package dependency; the payload type comes in as parameter T.
interface cfa_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/cfa_seg_mem.sv -----
// Segment table memory: one write port, one registered read port.
// Depends on cfa_pkg.
module cfa_seg_mem import cfa_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  seg_t            wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output seg_t            rdata_o
);
  seg_t mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/core/contiguous_fit_allocator.sv -----
// Contiguous fit allocator top level: sequencer around a segment table memory.
// Depends on cfa_pkg, cfa_if, cfa_seg_mem and the assertion header.
//
// One request at a time. Each word walks the segment table held in a
// single-port-write, registered-read memory, one entry per cycle in a scan.
// After reset a clearing pass is not needed: entry 0 is written by a single
// init state, and the fill count bounds every read. An allocate costs a scan
// of up to N entries (pick), plus, on a split, a move of the entries above the
// pick upward by one slot, each read then written (SMvRd, SMvWr). A free makes
// one compacting pass: read each entry, release it if owned, merge it into the
// pending output entry (held in a register) or write that entry out. A final
// statistics scan of the new table follows. The worst case per word is set by
// the one memory port. The result sits in an output register; a new word is
// taken once it has been taken.
`include "contiguous_fit_allocator_assert.svh"
module contiguous_fit_allocator import cfa_pkg::*; #(
  parameter int unsigned MEM_BYTES    = 1048576,
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cfa_if.sink   cfg,
  cfa_if.sink   req,
  cfa_if.source rsp
);
  localparam int unsigned IdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SEGMENTS);

  // sequencer states
  localparam logic [3:0] SInit  = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SPick  = 4'd2;
  localparam logic [3:0] SSplit = 4'd3;
  localparam logic [3:0] SMvRd  = 4'd4;
  localparam logic [3:0] SMvWr  = 4'd5;
  localparam logic [3:0] SPut   = 4'd6;
  localparam logic [3:0] SFree  = 4'd7;
  localparam logic [3:0] SFlush = 4'd8;
  localparam logic [3:0] SStat  = 4'd9;
  localparam logic [3:0] SDone  = 4'd10;

  logic [3:0]      state_q, state_d;
  logic [1:0]      pol_q;
  req_t            req_q;
  rsp_t            rsp_q, rsp_d;
  logic            rsp_vld_q, rsp_vld_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rd_q, rd_d;      // read pointer / issued address
  logic            rv_q, rv_d;      // read data valid next cycle
  logic [IdxW-1:0] ri_q, ri_d;      // index of data arriving
  logic            fnd_q, fnd_d;
  logic [IdxW-1:0] pick_q, pick_d;
  seg_t            pseg_q, pseg_d;  // picked segment / held merge entry
  logic [CntW-1:0] w_q, w_d;        // compaction write count
  logic            held_q, held_d;
  logic [LenW-1:0] tot_q, tot_d, big_q, big_d;
  logic [1:0]      st_q, st_d;
  logic [AddrW-1:0] addr_q, addr_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  seg_t            wdata, rdata, fs;
  logic            fit, better;

  cfa_seg_mem #(.Depth(MAX_SEGMENTS), .IdxW(IdxW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign cfg.ready = (state_q == SIdle) && !rsp_vld_q;
  assign req.ready = (state_q == SIdle) && !rsp_vld_q;
  assign rsp.valid = rsp_vld_q;
  assign rsp.data  = rsp_q;
  assign raddr     = rd_q[IdxW-1:0];

  always_comb begin
    fit    = rdata.free && (rdata.len >= req_q.request_size);
    better = (pol_q == PolBest)  ? (rdata.len < pseg_q.len) :
             (pol_q == PolWorst) ? (rdata.len > pseg_q.len) : 1'b0;
    fs       = rdata;
    if (!rdata.free && rdata.owner == req_q.owner_id) begin
      fs.free  = 1'b1;
      fs.owner = '0;
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rd_d = rd_q; rv_d = 1'b0; ri_d = ri_q;
    fnd_d = fnd_q; pick_d = pick_q; pseg_d = pseg_q; w_d = w_q; held_d = held_q;
    tot_d = tot_q; big_d = big_q; st_d = st_q; addr_d = addr_q;
    rsp_d = rsp_q; rsp_vld_d = rsp_vld_q;
    we = 1'b0; waddr = '0; wdata = '0;
    if (rsp.valid && rsp.ready) rsp_vld_d = 1'b0;
    unique case (state_q)
      SInit: begin
        we = 1'b1;
        wdata.start = '0; wdata.len = LenW'(MEM_BYTES); wdata.free = 1'b1;
        wdata.owner = '0;
        cnt_d = CntW'(1);
        state_d = SIdle;
      end
      SIdle: begin
        if (req.valid && req.ready) begin
          fnd_d = 1'b0; st_d = StOk; addr_d = '0; rd_d = '0; rv_d = 1'b1;
          ri_d = '0; w_d = '0; held_d = 1'b0;
          if (req.data.req_type == ReqFree) begin
            state_d = SFree;
          end else if (req.data.request_size == '0) begin
            st_d = StNoFit; state_d = SStat;
          end else begin
            state_d = SPick;
          end
          if (state_d != SFree) rv_d = 1'b1;
          rd_d = CntW'(1);
        end
      end
      // scan: data for ri_q arrives; next address already issued
      SPick: begin
        if (fit && (!fnd_q || better)) begin
          fnd_d = 1'b1; pick_d = ri_q; pseg_d = rdata;
        end
        if ((fit && pol_q != PolBest && pol_q != PolWorst) ||
            (CntW'(ri_q) + CntW'(1) >= cnt_q)) begin
          state_d = SSplit;
        end else begin
          ri_d = ri_q + IdxW'(1); rd_d = rd_q + CntW'(1); rv_d = 1'b1;
        end
        if (fit && !fnd_q && pol_q != PolBest && pol_q != PolWorst) begin
          fnd_d = 1'b1; pick_d = ri_q; pseg_d = rdata;
        end
      end
      SSplit: begin
        if (!fnd_q) begin
          st_d = StNoFit; state_d = SStat; rd_d = '0; rv_d = 1'b1;
        end else if (pseg_q.len == req_q.request_size) begin
          state_d = SPut;
        end else if (cnt_q >= MaxCnt) begin
          st_d = StFull; state_d = SStat; rd_d = '0; rv_d = 1'b1;
        end else begin
          // move entries cnt-1 down to pick+1 up by one
          rd_d = cnt_q - CntW'(1);
          state_d = SMvRd;
        end
      end
      SMvRd: begin
        if (rd_q <= CntW'(pick_q)) begin
          // write remainder at pick+1
          we = 1'b1; waddr = pick_q + IdxW'(1);
          wdata.start = pseg_q.start + AddrW'(req_q.request_size);
          wdata.len   = pseg_q.len - req_q.request_size;
          wdata.free  = 1'b1; wdata.owner = '0;
          cnt_d = cnt_q + CntW'(1);
          state_d = SPut;
        end else begin
          state_d = SMvWr;
        end
      end
      SMvWr: begin
        we = 1'b1; waddr = rd_q[IdxW-1:0] + IdxW'(1); wdata = rdata;
        rd_d = rd_q - CntW'(1);
        state_d = SMvRd;
      end
      SPut: begin
        we = 1'b1; waddr = pick_q;
        wdata.start = pseg_q.start; wdata.len = req_q.request_size;
        wdata.free = 1'b0; wdata.owner = req_q.owner_id;
        addr_d = pseg_q.start; st_d = StOk;
        rd_d = '0; rv_d = 1'b1; state_d = SStat;
      end
      // compacting free pass; pseg_q holds the pending output entry
      SFree: begin
        if (!rdata.free && rdata.owner == req_q.owner_id) fnd_d = 1'b1;
        if (held_q && pseg_q.free && fs.free) begin
          pseg_d.len = pseg_q.len + fs.len;
        end else begin
          if (held_q) begin
            we = 1'b1; waddr = w_q[IdxW-1:0]; wdata = pseg_q;
            w_d = w_q + CntW'(1);
          end
          pseg_d = fs; held_d = 1'b1;
        end
        if (CntW'(ri_q) + CntW'(1) >= cnt_q) begin
          state_d = SFlush;
        end else begin
          ri_d = ri_q + IdxW'(1); rd_d = rd_q + CntW'(1); rv_d = 1'b1;
        end
      end
      SFlush: begin
        // without a match the table is unchanged: the final write is suppressed
        we = 1'b1; waddr = w_q[IdxW-1:0]; wdata = pseg_q;
        if (fnd_q) cnt_d = w_q + CntW'(1);
        else st_d = StNoOwner;
        if (!fnd_q) begin
          we = 1'b0;
        end
        rd_d = '0; rv_d = 1'b1; state_d = SStat;
        tot_d = '0; big_d = '0; ri_d = '0;
      end
      SStat: begin
        // first cycle only issues address 0; rv_q marks live data
        if (rv_q && rd_q != '0) begin
          if (rdata.free) begin
            tot_d = tot_q + rdata.len;
            if (rdata.len > big_q) big_d = rdata.len;
          end
        end
        if (rd_q >= cnt_q) begin
          state_d = SDone;
        end else begin
          rd_d = rd_q + CntW'(1); rv_d = 1'b1;
        end
      end
      SDone: begin
        rsp_d.status = st_q; rsp_d.address = addr_q;
        rsp_d.total_free = tot_q; rsp_d.largest_free = big_q;
        rsp_d.external_frag = tot_q - big_q;
        // idle keeps address 0 on the port so the next word sees entry 0 first
        rd_d = '0;
        rsp_vld_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    if (state_q != SStat && state_d == SStat) begin
      tot_d = '0; big_d = '0;
    end
  end

  // In the no-owner case SFree wrote back entries that may differ only when a
  // match existed, so the pending writes are identical copies; safe.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit; pol_q <= PolFirst; rsp_vld_q <= 1'b0; cnt_q <= '0;
      rd_q <= '0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d; rsp_vld_q <= rsp_vld_d; cnt_q <= cnt_d;
      rd_q <= rd_d; rv_q <= rv_d;
      if (cfg.valid && cfg.ready) pol_q <= cfg.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) req_q <= req.data;
    ri_q <= ri_d; fnd_q <= fnd_d; pick_q <= pick_d; pseg_q <= pseg_d;
    w_q <= w_d; held_q <= held_d; tot_q <= tot_d; big_q <= big_d;
    st_q <= st_d; addr_q <= addr_d; rsp_q <= rsp_d;
  end

  `CFA_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, state_q != SInit,
    cnt_q <= MaxCnt && cnt_q != '0, "segment count out of range")
  `CFA_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, req.valid && req.ready,
    state_q == SIdle && !rsp_vld_q, "request taken while busy")
  `CFA_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp.valid && !rsp.ready,
    rsp.valid && $stable(rsp.data), "response dropped while stalled")
endmodule

// ----- sim/tb_contiguous_fit_allocator.sv -----
// Self-checking testbench for contiguous_fit_allocator.
// Depends on cfa_pkg, cfa_if and the allocator RTL; predicts each result word
// from a segment-table model held in a scoreboard class.
`timescale 1ns / 1ps
module tb_contiguous_fit_allocator;
  import cfa_pkg::*;

  localparam int unsigned MemBytes = 1048576;
  localparam int unsigned MaxSegs  = 64;
  localparam logic [1:0]  PolUnused = 2'd3;  // undefined code, acts as first fit

  // Segment table predictor plus the queue of expected result words.
  class alloc_scoreboard;
    logic [AddrW-1:0] seg_start [MaxSegs];
    logic [LenW-1:0]  seg_len   [MaxSegs];
    bit               seg_free  [MaxSegs];
    logic [OwnW-1:0]  seg_owner [MaxSegs];
    int unsigned      seg_count;
    logic [1:0]       policy;
    rsp_t             expected_q[$];
    int unsigned      errors;

    function void clear_table();
      for (int i = 0; i < MaxSegs; i++) begin
        seg_start[i] = '0;
        seg_len[i]   = '0;
        seg_free[i]  = 1'b0;
        seg_owner[i] = '0;
      end
      seg_len[0]  = LenW'(MemBytes);
      seg_free[0] = 1'b1;
      seg_count   = 1;
      policy      = PolFirst;
      errors      = 0;
    endfunction

    function int pick(logic [LenW-1:0] size);
      int chosen;
      chosen = -1;
      for (int i = 0; i < seg_count; i++) begin
        if (!seg_free[i] || seg_len[i] < size) continue;
        if (chosen < 0) begin
          chosen = i;
          if (policy != PolBest && policy != PolWorst) break;
        end else if (policy == PolBest && seg_len[i] < seg_len[chosen]) begin
          chosen = i;
        end else if (policy == PolWorst && seg_len[i] > seg_len[chosen]) begin
          chosen = i;
        end
      end
      return chosen;
    endfunction

    function logic [1:0] allocate(logic [OwnW-1:0] owner, logic [LenW-1:0] size,
                                  output logic [AddrW-1:0] addr);
      int k;
      addr = '0;
      if (size == 0) return StNoFit;
      k = pick(size);
      if (k < 0) return StNoFit;
      if (seg_len[k] > size) begin
        if (seg_count >= MaxSegs) return StFull;
        for (int j = seg_count; j > k + 1; j--) begin
          seg_start[j] = seg_start[j-1];
          seg_len[j]   = seg_len[j-1];
          seg_free[j]  = seg_free[j-1];
          seg_owner[j] = seg_owner[j-1];
        end
        seg_start[k+1] = seg_start[k] + AddrW'(size);
        seg_len[k+1]   = seg_len[k] - size;
        seg_free[k+1]  = 1'b1;
        seg_owner[k+1] = '0;
        seg_count++;
        seg_len[k] = size;
      end
      seg_free[k]  = 1'b0;
      seg_owner[k] = owner;
      addr = seg_start[k];
      return StOk;
    endfunction

    function logic [1:0] release_owner(logic [OwnW-1:0] owner);
      bit found;
      int unsigned w, old_count;
      found = 1'b0;
      for (int i = 0; i < seg_count; i++) begin
        if (!seg_free[i] && seg_owner[i] == owner) begin
          seg_free[i]  = 1'b1;
          seg_owner[i] = '0;
          found = 1'b1;
        end
      end
      if (!found) return StNoOwner;
      // compact: fold each free run into its first entry
      w = 0;
      old_count = seg_count;
      for (int r = 0; r < old_count; r++) begin
        if (w > 0 && seg_free[w-1] && seg_free[r]) begin
          seg_len[w-1] = seg_len[w-1] + seg_len[r];
        end else begin
          seg_start[w] = seg_start[r];
          seg_len[w]   = seg_len[r];
          seg_free[w]  = seg_free[r];
          seg_owner[w] = seg_owner[r];
          w++;
        end
      end
      for (int r = w; r < old_count; r++) begin
        seg_start[r] = '0;
        seg_len[r]   = '0;
        seg_free[r]  = 1'b0;
        seg_owner[r] = '0;
      end
      seg_count = w;
      return StOk;
    endfunction

    function void note_request(req_t rq);
      rsp_t exp_word;
      logic [AddrW-1:0] addr;
      logic [LenW-1:0] total, largest;
      addr = '0;
      if (rq.req_type == ReqAlloc)
        exp_word.status = allocate(rq.owner_id, rq.request_size, addr);
      else
        exp_word.status = release_owner(rq.owner_id);
      total = '0;
      largest = '0;
      for (int i = 0; i < seg_count; i++) begin
        if (seg_free[i]) begin
          total = total + seg_len[i];
          if (seg_len[i] > largest) largest = seg_len[i];
        end
      end
      exp_word.address       = addr;
      exp_word.total_free    = total;
      exp_word.largest_free  = largest;
      exp_word.external_frag = total - largest;
      expected_q = {expected_q, exp_word};
    endfunction

    function void check_response(rsp_t act);
      rsp_t exp_word;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp_word = expected_q.pop_front();
      if (act.status !== exp_word.status) begin
        $error("status: expected %0d, got %0d", exp_word.status, act.status);
        errors++;
      end
      if (act.address !== exp_word.address) begin
        $error("address: expected %0h, got %0h", exp_word.address, act.address);
        errors++;
      end
      if (act.total_free !== exp_word.total_free) begin
        $error("total_free: expected %0d, got %0d", exp_word.total_free, act.total_free);
        errors++;
      end
      if (act.largest_free !== exp_word.largest_free) begin
        $error("largest_free: expected %0d, got %0d",
               exp_word.largest_free, act.largest_free);
        errors++;
      end
      if (act.external_frag !== exp_word.external_frag) begin
        $error("external_frag: expected %0d, got %0d",
               exp_word.external_frag, act.external_frag);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  cfa_if #(.T(logic [1:0])) cfg_ch (clk_i);
  cfa_if #(.T(req_t))       req_ch (clk_i);
  cfa_if #(.T(rsp_t))       rsp_ch (clk_i);

  contiguous_fit_allocator #(
    .MEM_BYTES   (MemBytes),
    .MAX_SEGMENTS(MaxSegs)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg   (cfg_ch),
    .req   (req_ch),
    .rsp   (rsp_ch)
  );

  alloc_scoreboard sb = new();
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;  // set by stimulus to ask the receiver for a long stall

  // Receiver: ready pattern changes at the falling edge. Runs of full
  // throughput, runs of random stalls, and one long hold-off on request.
  initial begin
    int mode_left, mode;
    rsp_ch.ready = 1'b0;
    mode_left = 0;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        for (int i = 0; i < 3000; i++) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 200);
      end
      mode_left--;
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result monitor: sample at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
  end

  // Request acceptance feeds the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
  end

  // Burst state of the sender.
  int burst_left = 0;

  // Present one word; valid stays up across words inside a burst.
  task automatic send_word(input req_t rq);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.data  <= rq;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send(input logic rtype, input logic [OwnW-1:0] owner,
                      input logic [LenW-1:0] size);
    req_t rq;
    rq.req_type = rtype;
    rq.owner_id = owner;
    rq.request_size = size;
    send_word(rq);
  endtask

  // Drain results, let the block settle, then write the policy register.
  task automatic write_policy(input logic [1:0] pol);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= pol;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.policy = pol;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random request: owners mostly from a small pool so frees hit, sizes
  // mostly small so the table fills and splits; some full-range noise.
  task automatic random_request(input int free_pct);
    logic [OwnW-1:0] owner;
    logic [LenW-1:0] size;
    owner = ($urandom_range(0, 9) == 0) ? OwnW'($urandom) : OwnW'($urandom_range(0, 15));
    case ($urandom_range(0, 19))
      0: size = LenW'($urandom);
      1: size = LenW'($urandom_range(0, MemBytes));
      2: size = LenW'($urandom_range(1, 64));
      default: size = LenW'($urandom_range(1, 40000));
    endcase
    send(($urandom_range(0, 99) < free_pct) ? ReqFree : ReqAlloc, owner, size);
  endtask

  initial begin
    logic [1:0] pols[6];
    int free_pct[6];
    int wait_cycles;
    pols = '{PolFirst, PolBest, PolWorst, PolUnused, PolBest, PolWorst};
    free_pct = '{4, 25, 35, 20, 10, 45};
    sb.clear_table();
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: size zero, oversize, exact whole-memory fit, no room,
    // owner not found, owner extremes, release and merge.
    send(ReqAlloc, 16'd1, '0);
    send(ReqAlloc, 16'd2, '1);
    send(ReqAlloc, 16'd3, LenW'(MemBytes));
    send(ReqAlloc, 16'd4, 21'd1);
    send(ReqFree,  16'd9, '0);
    send(ReqFree,  16'd3, '1);
    send(ReqAlloc, 16'hFFFF, 21'd1);
    send(ReqAlloc, 16'h0000, 21'd100);
    send(ReqAlloc, 16'd5, 21'd1000);
    send(ReqAlloc, 16'hFFFF, 21'd50);
    send(ReqFree,  16'h0000, '0);
    send(ReqAlloc, 16'd6, 21'd100);
    send(ReqFree,  16'hFFFF, '0);
    send(ReqAlloc, 16'd7, LenW'(MemBytes - 1151));
    send(ReqAlloc, 16'd8, 21'd2);
    send(ReqFree,  16'd5, '0);
    send(ReqFree,  16'd6, '0);
    send(ReqFree,  16'd7, '0);
    send(ReqFree,  16'd7, '0);

    // Random phases, one per entry of the policy list (best and worst fit twice), extremes included.
    for (int p = 0; p < 6; p++) begin
      write_policy(pols[p]);
      for (int n = 0; n < 272; n++) begin
        if (p == 0 && n == 150) long_hold = 1'b1;
        random_request(free_pct[p]);
      end
    end
    req_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Finish once all results are in, plus a settle window.
  initial begin
    wait (stim_done);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/cfa_pkg.sv
rtl/core/cfa_if.sv
rtl/core/cfa_seg_mem.sv
rtl/core/contiguous_fit_allocator.sv
sim/tb_contiguous_fit_allocator.sv
